/* design/pmmd_pkg.sv */
// ----------------------------------------------------------------------------
// pmmd_pkg: shared types and constants for the mass-matrix deposit block
// Action codes, queued item layout, deposit target map and status bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmmd_pkg;

  localparam int DEF_MAX_CELLS_X = 64;
  localparam int DEF_MAX_CELLS_Y = 64;
  localparam int DEF_ACC_WIDTH   = 48;

  localparam int COMPONENTS  = 9;
  localparam int ROW_LEN     = 3;
  localparam int TABLES      = 5;
  localparam int TARGETS     = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_WIDTH   = 48;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_GEOM  = 2'd1;
  localparam logic [1:0] ACT_ROW   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CELLS_X = 2'd0;
  localparam logic [1:0] REG_CELLS_Y = 2'd1;
  localparam logic [1:0] REG_SCALE   = 2'd2;

  // reset values of the configuration registers
  localparam logic [6:0]  RST_CELLS_X = 7'd64;
  localparam logic [6:0]  RST_CELLS_Y = 7'd64;
  localparam logic [31:0] RST_SCALE   = 32'd65536;

  typedef struct packed {
    logic [1:0]         action;
    logic               sel_ok;   // read selector names a real table and component
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [5:0]         next_x;
    logic [5:0]         next_y;
    logic [15:0]        weight_x;
    logic [15:0]        weight_y;
    logic [15:0]        weight_next_x;
    logic [15:0]        weight_next_y;
    logic signed [15:0] alpha_first;
    logic signed [15:0] alpha_second;
    logic signed [15:0] alpha_third;
  } item_t;

  // one deposit target: table, cell choice and weight choice per factor
  typedef struct packed {
    logic [2:0] tab;
    logic       use_nx;
    logic       use_ny;
    logic       a_next;
    logic       b_next;
    logic       c_next;
    logic       d_next;
  } target_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  function automatic target_t target_info(input logic [3:0] idx);
    target_t t;
    case (idx)
      4'd0:    t = '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      4'd1:    t = '{3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      4'd2:    t = '{3'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      4'd3:    t = '{3'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
      4'd4:    t = '{3'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      4'd5:    t = '{3'd1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      4'd6:    t = '{3'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      4'd7:    t = '{3'd2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      4'd8:    t = '{3'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
      4'd9:    t = '{3'd4, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      default: t = '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    endcase
    return t;
  endfunction

endpackage

/* design/pmmd_front.sv */
// ----------------------------------------------------------------------------
// pmmd_front: input acceptance and classification
// Takes input transfers, flags valid read selectors and queues items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmmd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pmmd_pkg::item_t         in_item,
  input  pmmd_pkg::back_status_t  status,
  output logic                    q_valid,
  output pmmd_pkg::item_t         q_item,
  input  logic                    q_pop
);

  localparam int QD = pmmd_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  pmmd_pkg::item_t    q_mem_r [QD];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               push;
  pmmd_pkg::item_t    cls_item;

  // classify: a read selector is good only for a real table and component
  always_comb begin
    cls_item = in_item;
    cls_item.sel_ok = (in_item.next_x < 6'(pmmd_pkg::TABLES)) &&
                      (in_item.next_y < 6'(pmmd_pkg::COMPONENTS));
  end

  assign in_ready = (count_r != CW'(QD)) && !status.init_busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

/* design/pmmd_bank.sv */
// ----------------------------------------------------------------------------
// pmmd_bank: one coupling table
// Single-port-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmmd_bank #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* design/pmmd_back.sv */
// ----------------------------------------------------------------------------
// pmmd_back: deposit sequencer
// Executes queued items: table sweeps, geometry latch, weighted saturating
// read-modify-write updates and accumulator readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmmd_back #(
  parameter int MAX_CELLS_X = pmmd_pkg::DEF_MAX_CELLS_X,
  parameter int MAX_CELLS_Y = pmmd_pkg::DEF_MAX_CELLS_Y,
  parameter int ACC_WIDTH   = pmmd_pkg::DEF_ACC_WIDTH,
  parameter int XW          = $clog2(MAX_CELLS_X + 1),
  parameter int YW          = $clog2(MAX_CELLS_Y + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [XW-1:0]                 eff_x,
  input  logic [YW-1:0]                 eff_y,
  input  logic [31:0]                   scale,
  input  logic                          q_valid,
  input  pmmd_pkg::item_t               q_item,
  output logic                          q_pop,
  output pmmd_pkg::back_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pmmd_pkg::OUT_WIDTH-1:0] out_entry_value,
  output logic                          out_saturated
);

  localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y * pmmd_pkg::COMPONENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = ACC_WIDTH + 1;
  localparam int TW    = 50;
  localparam int SW    = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 1;
  localparam int CMPW0 = (XW > YW) ? XW : YW;
  localparam int CMPW  = (CMPW0 > 7) ? CMPW0 : 7;
  localparam int NT    = pmmd_pkg::TABLES;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_CLR_PREP = 4'd2;
  localparam logic [3:0] ST_CLR      = 4'd3;
  localparam logic [3:0] ST_RD_ADDR  = 4'd4;
  localparam logic [3:0] ST_RD_MEM   = 4'd5;
  localparam logic [3:0] ST_RD_DATA  = 4'd6;
  localparam logic [3:0] ST_T_PREP   = 4'd7;
  localparam logic [3:0] ST_T_PROD   = 4'd8;
  localparam logic [3:0] ST_T_W      = 4'd9;
  localparam logic [3:0] ST_T_S      = 4'd10;
  localparam logic [3:0] ST_C_MUL    = 4'd11;
  localparam logic [3:0] ST_C_ACC    = 4'd12;

  localparam logic signed [SW-1:0] ACC_MAX = SW'((65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - SW'(1);

  logic [3:0]             state_r, state_nxt;
  pmmd_pkg::item_t        cur_r, cur_nxt;
  logic [5:0]             lat_cx_r, lat_cy_r, lat_nx_r, lat_ny_r;
  logic [15:0]            lat_wx_r, lat_wy_r, lat_wnx_r, lat_wny_r;
  logic                   lat_en;
  logic [1:0]             row_r, row_nxt;
  logic [3:0]             tgt_r, tgt_nxt;
  logic [1:0]             k_r, k_nxt;
  logic [2:0]             tab_r, tab_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [AW-1:0]          base_r, base_nxt;
  logic [AW-1:0]          last_r, last_nxt;
  logic                   hit_r, hit_nxt;
  logic [31:0]            ab_r, ab_nxt, cd_r, cd_nxt;
  logic [63:0]            p_r, p_nxt;
  logic [47:0]            ws_r, ws_nxt;
  logic [32:0]            s_r, s_nxt;
  logic signed [TW-1:0]   term_r, term_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [pmmd_pkg::OUT_WIDTH-1:0] out_val_r, out_val_nxt;
  logic                   out_sat_r, out_sat_nxt;

  logic [NT-1:0]          bank_we;
  logic [MW-1:0]          bank_wdata;
  logic [MW-1:0]          bank_rdata [NT];
  logic [MW-1:0]          sel_rdata;
  logic [2:0]             sel_tab;

  pmmd_pkg::target_t      tinfo;
  logic [5:0]             t_x, t_y;
  logic [15:0]            t_wa, t_wb, t_wc, t_wd;
  logic [15:0]            w_val;
  logic signed [15:0]     alpha_k;
  logic signed [SW-1:0]   sum;
  logic signed [63:0]     acc64;

  // table banks
  for (genvar b = 0; b < NT; b++) begin : g_bank
    pmmd_bank #(.DEPTH(DEPTH), .WIDTH(MW)) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .addr  (addr_r),
      .wdata (bank_wdata),
      .rdata (bank_rdata[b])
    );
  end

  assign sel_tab   = (tab_r < 3'(NT)) ? tab_r : 3'd0;
  assign sel_rdata = bank_rdata[sel_tab];

  // target decode for the current deposit
  always_comb begin
    tinfo = pmmd_pkg::target_info(tgt_r);
    t_x   = tinfo.use_nx ? lat_nx_r : lat_cx_r;
    t_y   = tinfo.use_ny ? lat_ny_r : lat_cy_r;
    t_wa  = tinfo.a_next ? lat_wnx_r : lat_wx_r;
    t_wb  = tinfo.b_next ? lat_wny_r : lat_wy_r;
    t_wc  = tinfo.c_next ? lat_wnx_r : lat_wx_r;
    t_wd  = tinfo.d_next ? lat_wny_r : lat_wy_r;
  end

  // rounding of the weight product, component select, saturating add
  always_comb begin
    w_val = 16'((p_r + (64'd1 << 44)) >> 45);
    case (k_r)
      2'd0:    alpha_k = cur_r.alpha_first;
      2'd1:    alpha_k = cur_r.alpha_second;
      default: alpha_k = cur_r.alpha_third;
    endcase
    sum   = SW'($signed(sel_rdata[ACC_WIDTH-1:0])) + SW'(term_r);
    acc64 = 64'($signed(sel_rdata[ACC_WIDTH-1:0]));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    lat_en        = 1'b0;
    row_nxt       = row_r;
    tgt_nxt       = tgt_r;
    k_nxt         = k_r;
    tab_nxt       = tab_r;
    addr_nxt      = addr_r;
    base_nxt      = base_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    ab_nxt        = ab_r;
    cd_nxt        = cd_r;
    p_nxt         = p_r;
    ws_nxt        = ws_r;
    s_nxt         = s_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_sat_nxt   = out_sat_r;
    q_pop         = 1'b0;
    bank_we       = '0;
    bank_wdata    = '0;

    case (state_r)
      ST_INIT: begin
        bank_we = '1;
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          case (q_item.action)
            pmmd_pkg::ACT_CLEAR: state_nxt = ST_CLR_PREP;
            pmmd_pkg::ACT_GEOM: begin
              lat_en  = 1'b1;
              row_nxt = 2'd0;
            end
            pmmd_pkg::ACT_ROW: begin
              tgt_nxt   = 4'd0;
              state_nxt = ST_T_PREP;
            end
            default: state_nxt = ST_RD_ADDR;
          endcase
        end
      end
      ST_CLR_PREP: begin
        last_nxt  = AW'(AW'(AW'(eff_x) * AW'(eff_y)) * AW'(pmmd_pkg::COMPONENTS)) - 1'b1;
        addr_nxt  = '0;
        state_nxt = ST_CLR;
      end
      ST_CLR: begin
        bank_we = '1;
        if (addr_r == last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_RD_ADDR: begin
        hit_nxt   = cur_r.sel_ok && (CMPW'(cur_r.cell_x) < CMPW'(eff_x)) &&
                    (CMPW'(cur_r.cell_y) < CMPW'(eff_y));
        addr_nxt  = AW'((AW'(cur_r.cell_x) + AW'(AW'(cur_r.cell_y) * AW'(eff_x))) *
                    AW'(pmmd_pkg::COMPONENTS)) + AW'(cur_r.next_y);
        tab_nxt   = cur_r.next_x[2:0];
        state_nxt = ST_RD_MEM;
      end
      ST_RD_MEM: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = hit_r ? acc64[pmmd_pkg::OUT_WIDTH-1:0] : '0;
          out_sat_nxt   = hit_r ? sel_rdata[ACC_WIDTH] : 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_T_PREP: begin
        ab_nxt    = t_wa * t_wb;
        cd_nxt    = t_wc * t_wd;
        tab_nxt   = tinfo.tab;
        hit_nxt   = (CMPW'(t_x) < CMPW'(eff_x)) && (CMPW'(t_y) < CMPW'(eff_y));
        base_nxt  = AW'((AW'(t_x) + AW'(AW'(t_y) * AW'(eff_x))) *
                    AW'(pmmd_pkg::COMPONENTS)) + AW'(AW'(row_r) * AW'(pmmd_pkg::ROW_LEN));
        state_nxt = ST_T_PROD;
      end
      ST_T_PROD: begin
        p_nxt     = ab_r * cd_r;
        state_nxt = ST_T_W;
      end
      ST_T_W: begin
        ws_nxt    = w_val * scale;
        state_nxt = ST_T_S;
      end
      ST_T_S: begin
        s_nxt    = 33'((ws_r + 48'd16384) >> 15);
        addr_nxt = base_r;
        k_nxt    = 2'd0;
        if (hit_r) begin
          state_nxt = ST_C_MUL;
        end else if (tgt_r == 4'(pmmd_pkg::TARGETS - 1)) begin
          row_nxt   = (row_r >= 2'd2) ? 2'd0 : row_r + 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          tgt_nxt   = tgt_r + 1'b1;
          state_nxt = ST_T_PREP;
        end
      end
      ST_C_MUL: begin
        term_nxt  = TW'(alpha_k) * TW'($signed({1'b0, s_r}));
        state_nxt = ST_C_ACC;
      end
      ST_C_ACC: begin
        bank_we[sel_tab] = 1'b1;
        if (sum > ACC_MAX) begin
          bank_wdata = {1'b1, ACC_MAX[ACC_WIDTH-1:0]};
        end else if (sum < ACC_MIN) begin
          bank_wdata = {1'b1, ACC_MIN[ACC_WIDTH-1:0]};
        end else begin
          bank_wdata = {sel_rdata[ACC_WIDTH], sum[ACC_WIDTH-1:0]};
        end
        addr_nxt = addr_r + 1'b1;
        if (k_r != 2'd2) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_C_MUL;
        end else if (tgt_r == 4'(pmmd_pkg::TARGETS - 1)) begin
          row_nxt   = (row_r >= 2'd2) ? 2'd0 : row_r + 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          tgt_nxt   = tgt_r + 1'b1;
          state_nxt = ST_T_PREP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      row_r       <= '0;
      tgt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      lat_cx_r    <= '0;
      lat_cy_r    <= '0;
      lat_nx_r    <= '0;
      lat_ny_r    <= '0;
      lat_wx_r    <= '0;
      lat_wy_r    <= '0;
      lat_wnx_r   <= '0;
      lat_wny_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      row_r       <= row_nxt;
      tgt_r       <= tgt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (lat_en) begin
        lat_cx_r  <= q_item.cell_x;
        lat_cy_r  <= q_item.cell_y;
        lat_nx_r  <= q_item.next_x;
        lat_ny_r  <= q_item.next_y;
        lat_wx_r  <= q_item.weight_x;
        lat_wy_r  <= q_item.weight_y;
        lat_wnx_r <= q_item.weight_next_x;
        lat_wny_r <= q_item.weight_next_y;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    tab_r     <= tab_nxt;
    base_r    <= base_nxt;
    last_r    <= last_nxt;
    hit_r     <= hit_nxt;
    ab_r      <= ab_nxt;
    cd_r      <= cd_nxt;
    p_r       <= p_nxt;
    ws_r      <= ws_nxt;
    s_r       <= s_nxt;
    term_r    <= term_nxt;
    out_val_r <= out_val_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign status.init_busy = (state_r == ST_INIT);
  assign out_valid        = out_valid_r;
  assign out_entry_value  = out_val_r;
  assign out_saturated    = out_sat_r;

  // a new result only comes out of the readout state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RD_DATA)
    else $error("result appeared outside readout");

  // tables are written only by sweeps and accumulate steps
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_we != '0) |-> (state_r == ST_INIT || state_r == ST_CLR || state_r == ST_C_ACC))
    else $error("table write outside sweep or accumulate");

  // an accumulate step writes exactly one table
  a_we_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_C_ACC |-> $onehot(bank_we))
    else $error("accumulate wrote other than one table");

  // deposit counters stay within a row's ten targets and three components
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    tgt_r < 4'(pmmd_pkg::TARGETS) && k_r != 2'd3)
    else $error("deposit counter out of range");

endmodule

/* design/particle_mass_matrix_deposit.sv */
// ----------------------------------------------------------------------------
// particle_mass_matrix_deposit: mass-matrix scatter-add into five tables
// Front queue, back sequencer with five banked tables, configuration regs.
// ----------------------------------------------------------------------------
// Read: address, memory and data states; waits while the last result is unread.
// Geometry: latched at pop. Alpha row: weight steps per target, then one update
// per component if in grid. Clear: cells_x*cells_y*9 entries, one entry of all
// five tables a cycle. Reset: synchronous; then MAX_CELLS_X*MAX_CELLS_Y*9 entries
// (36864 by default) are cleared, with in_ready low, cfg writes still taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_mass_matrix_deposit #(
  parameter int MAX_CELLS_X = pmmd_pkg::DEF_MAX_CELLS_X,
  parameter int MAX_CELLS_Y = pmmd_pkg::DEF_MAX_CELLS_Y,
  parameter int ACC_WIDTH   = pmmd_pkg::DEF_ACC_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [5:0]         in_cell_x,
  input  logic [5:0]         in_cell_y,
  input  logic [5:0]         in_next_x,
  input  logic [5:0]         in_next_y,
  input  logic [15:0]        in_weight_x,
  input  logic [15:0]        in_weight_y,
  input  logic [15:0]        in_weight_next_x,
  input  logic [15:0]        in_weight_next_y,
  input  logic signed [15:0] in_alpha_first,
  input  logic signed [15:0] in_alpha_second,
  input  logic signed [15:0] in_alpha_third,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_entry_value,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int XW = $clog2(MAX_CELLS_X + 1);
  localparam int YW = $clog2(MAX_CELLS_Y + 1);
  localparam int CW0 = (XW > YW) ? XW : YW;
  localparam int CW = (CW0 > 7) ? CW0 : 7;

  logic [6:0]             cells_x_r, cells_y_r;
  logic [31:0]            scale_r;
  logic [XW-1:0]          eff_x;
  logic [YW-1:0]          eff_y;
  pmmd_pkg::item_t        in_item, q_item;
  pmmd_pkg::back_status_t status;
  logic                   q_valid, q_pop;
  logic [47:0]            out_val;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= pmmd_pkg::RST_CELLS_X;
      cells_y_r <= pmmd_pkg::RST_CELLS_Y;
      scale_r   <= pmmd_pkg::RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmmd_pkg::REG_CELLS_X: cells_x_r <= cfg_data[6:0];
        pmmd_pkg::REG_CELLS_Y: cells_y_r <= cfg_data[6:0];
        pmmd_pkg::REG_SCALE:   scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective grid size: zero becomes one, clamp to the table size
  always_comb begin
    if (cells_x_r == '0) begin
      eff_x = XW'(1);
    end else if (CW'(cells_x_r) > CW'(MAX_CELLS_X)) begin
      eff_x = XW'(MAX_CELLS_X);
    end else begin
      eff_x = XW'(cells_x_r);
    end
    if (cells_y_r == '0) begin
      eff_y = YW'(1);
    end else if (CW'(cells_y_r) > CW'(MAX_CELLS_Y)) begin
      eff_y = YW'(MAX_CELLS_Y);
    end else begin
      eff_y = YW'(cells_y_r);
    end
  end

  // pack the input transfer
  always_comb begin
    in_item.action        = in_action;
    in_item.sel_ok        = 1'b0;
    in_item.cell_x        = in_cell_x;
    in_item.cell_y        = in_cell_y;
    in_item.next_x        = in_next_x;
    in_item.next_y        = in_next_y;
    in_item.weight_x      = in_weight_x;
    in_item.weight_y      = in_weight_y;
    in_item.weight_next_x = in_weight_next_x;
    in_item.weight_next_y = in_weight_next_y;
    in_item.alpha_first   = in_alpha_first;
    in_item.alpha_second  = in_alpha_second;
    in_item.alpha_third   = in_alpha_third;
  end

  pmmd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .status   (status),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pmmd_back #(
    .MAX_CELLS_X (MAX_CELLS_X),
    .MAX_CELLS_Y (MAX_CELLS_Y),
    .ACC_WIDTH   (ACC_WIDTH),
    .XW          (XW),
    .YW          (YW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_x           (eff_x),
    .eff_y           (eff_y),
    .scale           (scale_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_val),
    .out_saturated   (out_saturated)
  );

  assign out_entry_value = $signed(out_val);

endmodule
